// File: design/base64_stream_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// base64 stream decoder assertion macros
// Concurrent assertion forms used by the decoder queue.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("b64d assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("b64d assertion failed");

`endif

// File: design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned SymW   = 6;
    localparam int unsigned AccW   = 18;
    localparam int unsigned Groups = 3;

    typedef enum logic [1:0] {
        SymData,
        SymPad,
        SymSpace,
        SymBad
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t         kind;
        logic [SymW-1:0]   value;
    } sym_class_t;

    // One queue entry: up to three data bytes, optionally followed by the
    // end status item.
    typedef struct packed {
        logic [Groups-1:0][CharW-1:0] data;
        logic [1:0]                   nbytes;
        logic                         has_end;
        logic                         err;
    } b64d_cmd_t;

    localparam logic [CharW-1:0] CharHigh = 8'h80;

    function automatic sym_class_t classify_char(input logic [CharW-1:0] c);
        sym_class_t r;
        r.kind  = SymBad;
        r.value = '0;
        priority if (c >= CharHigh)
        begin
            r.kind = SymBad;
        end
        else if (c >= 8'h41 && c <= 8'h5A)
        begin
            r.kind  = SymData;
            r.value = SymW'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r.kind  = SymData;
            r.value = SymW'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r.kind  = SymData;
            r.value = SymW'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B || c == 8'h2D)
        begin
            r.kind  = SymData;
            r.value = SymW'(62);
        end
        else if (c == 8'h2F || c == 8'h5F)
        begin
            r.kind  = SymData;
            r.value = SymW'(63);
        end
        else if (c == 8'h3D)
        begin
            r.kind = SymPad;
        end
        else if (c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20)
        begin
            r.kind = SymSpace;
        end
        return r;
    endfunction

endpackage

// File: design/b64d_char_if.sv
// ----------------------------------------------------------------------------
// b64d_char_if
// Text character channel: valid/ready handshake with one character.
// ----------------------------------------------------------------------------
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       final_char;

    modport source (output valid, output text_char, output final_char, input ready);
    modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

// File: design/b64d_byte_if.sv
// ----------------------------------------------------------------------------
// b64d_byte_if
// Decoded result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_status;
    logic       decode_error;

    modport source (output valid, output out_byte, output end_status,
                    output decode_error, input ready);
    modport sink   (input valid, input out_byte, input end_status,
                    input decode_error, output ready);
endinterface

// File: design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks group and padding state, queues results.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    b64d_char_if.sink   text,
    input  logic        queue_full,
    output logic        push,
    output b64d_cmd_t   push_cmd
);

    logic [AccW-1:0] acc_reg, acc_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            fpad_reg, fpad_next;
    logic            pdone_reg, pdone_next;
    logic            err_reg, err_next;

    sym_class_t          sym;
    logic [AccW+SymW-1:0] full_group;
    logic                accept;

    assign text.ready = !queue_full;
    assign accept     = text.valid && text.ready;
    assign sym        = classify_char(text.text_char);
    assign full_group = {acc_reg, sym.value};

    always_comb
    begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        fpad_next  = fpad_reg;
        pdone_next = pdone_reg;
        err_next   = err_reg;
        push_cmd   = '0;

        if (err_reg || sym.kind == SymSpace)
        begin
            // skip
        end
        else if (sym.kind == SymBad || pdone_reg)
        begin
            err_next = 1'b1;
        end
        else if (sym.kind == SymPad)
        begin
            if (fpad_reg)
            begin
                push_cmd.nbytes  = 2'd1;
                push_cmd.data[0] = acc_reg[11:4];
                fpad_next  = 1'b0;
                pdone_next = 1'b1;
                cnt_next   = '0;
                acc_next   = '0;
            end
            else if (cnt_reg == 2'd3)
            begin
                if (acc_reg[1:0] != 2'b00)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    push_cmd.nbytes  = 2'd2;
                    push_cmd.data[0] = acc_reg[17:10];
                    push_cmd.data[1] = acc_reg[9:2];
                    pdone_next = 1'b1;
                    cnt_next   = '0;
                    acc_next   = '0;
                end
            end
            else if (cnt_reg == 2'd2)
            begin
                if (acc_reg[3:0] != 4'h0)
                    err_next = 1'b1;
                else
                    fpad_next = 1'b1;
            end
            else
            begin
                err_next = 1'b1;
            end
        end
        else if (fpad_reg)
        begin
            err_next = 1'b1;
        end
        else if (cnt_reg == 2'd3)
        begin
            push_cmd.nbytes  = 2'd3;
            push_cmd.data[0] = full_group[23:16];
            push_cmd.data[1] = full_group[15:8];
            push_cmd.data[2] = full_group[7:0];
            cnt_next = '0;
            acc_next = '0;
        end
        else
        begin
            acc_next = {acc_reg[AccW-SymW-1:0], sym.value};
            cnt_next = cnt_reg + 2'd1;
        end

        if (text.final_char)
        begin
            push_cmd.has_end = 1'b1;
            push_cmd.err     = err_next || (cnt_next != 2'd0) || fpad_next;
            acc_next   = '0;
            cnt_next   = '0;
            fpad_next  = 1'b0;
            pdone_next = 1'b0;
            err_next   = 1'b0;
        end
    end

    assign push = accept && (push_cmd.has_end || push_cmd.nbytes != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            fpad_reg  <= 1'b0;
            pdone_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            fpad_reg  <= fpad_next;
            pdone_reg <= pdone_next;
            err_reg   <= err_next;
        end
    end

endmodule

// File: design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short FIFO of result transactions between the front and the back.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_top_macros.svh"

module b64d_queue
    import b64d_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  b64d_cmd_t push_cmd,
    input  logic      pop,
    output logic      full,
    output logic      head_valid,
    output b64d_cmd_t head_cmd
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    b64d_cmd_t       slots_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = (count_reg == CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    `B64D_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
    `B64D_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, head_valid)
    `B64D_ASSERT_NEXT(a_count_tracks, clk, rst_n, push && !pop, count_reg != '0)

endmodule

// File: design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Unpacks queued transactions into result items through an output register.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  b64d_cmd_t   head_cmd,
    output logic        pop,
    b64d_byte_if.source decoded
);

    b64d_cmd_t  cmd_reg;
    logic       cmd_valid_reg;
    logic [1:0] idx_reg;

    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       err_reg;

    logic [2:0] total;
    logic       last_item;
    logic       load;
    logic       item_is_data;

    assign total        = {1'b0, cmd_reg.nbytes} + {2'b00, cmd_reg.has_end};
    assign last_item    = ({1'b0, idx_reg} + 3'd1) == total;
    assign item_is_data = idx_reg < cmd_reg.nbytes;
    assign load         = cmd_valid_reg && (!out_valid_reg || decoded.ready);
    assign pop          = head_valid && (!cmd_valid_reg || (load && last_item));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cmd_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (load && last_item)
            begin
                cmd_valid_reg <= 1'b0;
            end
            else if (load)
            begin
                idx_reg <= idx_reg + 2'd1;
            end

            if (load)
                out_valid_reg <= 1'b1;
            else if (decoded.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= head_cmd;
        if (load)
        begin
            byte_reg <= item_is_data ? cmd_reg.data[idx_reg] : '0;
            end_reg  <= !item_is_data;
            err_reg  <= !item_is_data && cmd_reg.err;
        end
    end

    assign decoded.valid        = out_valid_reg;
    assign decoded.out_byte     = byte_reg;
    assign decoded.end_status   = end_reg;
    assign decoded.decode_error = err_reg;

endmodule

// File: design/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 text decoder with a decoupled front and back end.
// ----------------------------------------------------------------------------
// Usage:
//   text    : one character per transaction; final_char marks the last one.
//   decoded : one result item per transaction, data bytes in order, then one
//             end_status item per text carrying decode_error.
// Throughput: one character per cycle. Each group of four symbols yields up
//   to three bytes; results leave at one per cycle while decoded.ready is
//   high, and the front keeps taking characters until the result queue
//   (QueueDepth transactions) fills. Path: the first result of a character
//   passes the queue slot, the command register and the output register,
//   when no earlier result is still pending and the output is not stalled.
// Reset: rst_n clears the group state, empties the queue and drops any
//   pending result. The decoder is ready the first cycle after reset.
// Stall: while decoded.ready is low the output register holds its item; the
//   queue absorbs further results and text.ready falls only when it is full.
// Bytes delivered before an error are valid only if the end item is clean.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top
    import b64d_pkg::*;
#(
    parameter int unsigned QueueDepth = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    b64d_char_if.sink   text,
    b64d_byte_if.source decoded
);

    logic      queue_full;
    logic      push;
    b64d_cmd_t push_cmd;
    logic      pop;
    logic      head_valid;
    b64d_cmd_t head_cmd;

    // Classify characters and advance the group state, one per cycle while the result queue is not full.
    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Hold result transactions so either side can stall on its own.
    b64d_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Drain each transaction as a run of result items.
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .decoded    (decoded)
    );

endmodule

// File: tb/tb_base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_top
// Self-checking bench for the streaming base64 decoder. A tracker class keeps
// its own group state, predicts every decoded byte and end status item from
// the accepted characters, and compares each delivered result in order.
// Stimulus is a short directed set followed by random texts: mostly
// well-formed base64 with random content, whitespace and both alphabets, some
// spoiled on purpose, and some raw noise. Both sides of the design idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_top;
    import b64d_pkg::*;

    localparam int          HalfPeriod  = 4;
    localparam int          LimitCycles = 200000;
    localparam int          RandomItems = 240;
    localparam int          HoldCycles  = 90;
    localparam int          SettleWait  = 8;
    localparam logic [7:0]  TabChar     = 8'h09;
    localparam logic [7:0]  LfChar      = 8'h0A;
    localparam logic [7:0]  CrChar      = 8'h0D;
    localparam logic [7:0]  SpaceChar   = 8'h20;
    localparam logic [7:0]  PadChar     = 8'h3D;
    localparam logic [7:0]  MaxChar     = 8'hFF;

    // One decoded result as it leaves the design.
    typedef struct packed {
        logic [7:0] data;
        logic       end_flag;
        logic       err_flag;
    } result_item_t;

    // ------------------------------------------------------------------------
    // Decode tracker: mirrors the group state of the decoder and holds the
    // results still owed by the design.
    // ------------------------------------------------------------------------
    class decode_tracker;
        logic [17:0]    accum;
        logic [1:0]     group_len;
        logic           half_pad;
        logic           pad_closed;
        logic           text_bad;
        result_item_t   owed_q[$];
        int             mismatches;
        int             texts;
        int             bad_texts;
        int             data_bytes;

        function new();
            clear_text();
            mismatches = 0;
            texts      = 0;
            bad_texts  = 0;
            data_bytes = 0;
        endfunction

        function void clear_text();
            accum      = '0;
            group_len  = '0;
            half_pad   = 1'b0;
            pad_closed = 1'b0;
            text_bad   = 1'b0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function sym_kind_t sort_char(input logic [7:0] c, output logic [5:0] v);
            v = '0;
            if (c >= 8'h80)
                return SymBad;
            if (c >= "A" && c <= "Z")
            begin
                v = 6'(c - "A");
                return SymData;
            end
            if (c >= "a" && c <= "z")
            begin
                v = 6'(c - "a" + 8'd26);
                return SymData;
            end
            if (c >= "0" && c <= "9")
            begin
                v = 6'(c - "0" + 8'd52);
                return SymData;
            end
            if (c == "+" || c == "-")
            begin
                v = 6'd62;
                return SymData;
            end
            if (c == "/" || c == "_")
            begin
                v = 6'd63;
                return SymData;
            end
            if (c == PadChar)
                return SymPad;
            if (c == TabChar || c == LfChar || c == CrChar || c == SpaceChar)
                return SymSpace;
            return SymBad;
        endfunction

        function void owe_byte(input logic [7:0] b);
            owed_q.push_back('{data: b, end_flag: 1'b0, err_flag: 1'b0});
            data_bytes++;
        endfunction

        // Advance the group state by one accepted character.
        function void accept_char(input logic [7:0] c, input logic last);
            sym_kind_t   kind;
            logic [5:0]  v;
            logic [23:0] full;
            logic        bad;
            kind = sort_char(c, v);
            if (text_bad || kind == SymSpace)
            begin
                // whitespace, or the text is already lost
            end
            else if (kind == SymBad || pad_closed)
                text_bad = 1'b1;
            else if (kind == SymPad)
            begin
                if (half_pad)
                begin
                    owe_byte(accum[11:4]);
                    half_pad   = 1'b0;
                    pad_closed = 1'b1;
                    group_len  = '0;
                    accum      = '0;
                end
                else if (group_len == 2'd3)
                begin
                    if (accum[1:0] != 2'b00)
                        text_bad = 1'b1;
                    else
                    begin
                        owe_byte(accum[17:10]);
                        owe_byte(accum[9:2]);
                        pad_closed = 1'b1;
                        group_len  = '0;
                        accum      = '0;
                    end
                end
                else if (group_len == 2'd2)
                begin
                    if (accum[3:0] != 4'h0)
                        text_bad = 1'b1;
                    else
                        half_pad = 1'b1;
                end
                else
                    text_bad = 1'b1;
            end
            else if (half_pad)
                text_bad = 1'b1;
            else if (group_len == 2'd3)
            begin
                full = {accum, v};
                owe_byte(full[23:16]);
                owe_byte(full[15:8]);
                owe_byte(full[7:0]);
                group_len = '0;
                accum     = '0;
            end
            else
            begin
                accum     = {accum[11:0], v};
                group_len = group_len + 2'd1;
            end

            if (last)
            begin
                bad = text_bad || group_len != 2'd0 || half_pad;
                owed_q.push_back('{data: 8'h00, end_flag: 1'b1, err_flag: bad});
                texts++;
                if (bad)
                    bad_texts++;
                clear_text();
            end
        endfunction

        // Compare one delivered result with the oldest owed one.
        function void take_result(input logic [7:0] b, input logic e, input logic er);
            result_item_t want;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got byte %02h end %b err %b",
                         $time, b, e, er);
                return;
            end
            want = owed_q.pop_front();
            if (b !== want.data)
            begin
                mismatches++;
                $display("%0t: out_byte mismatch: expected %02h, got %02h",
                         $time, want.data, b);
            end
            if (e !== want.end_flag)
            begin
                mismatches++;
                $display("%0t: end_status mismatch: expected %b, got %b",
                         $time, want.end_flag, e);
            end
            if (er !== want.err_flag)
            begin
                mismatches++;
                $display("%0t: decode_error mismatch: expected %b, got %b",
                         $time, want.err_flag, er);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the design
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    b64d_char_if char_bus();
    b64d_byte_if byte_bus();

    decode_tracker tracker = new();

    logic [7:0] text_buf[$];        // text being built for the next send
    int         burst_left    = 0;  // transactions left in the current burst
    int         sent_chars    = 0;  // characters accepted in the random phase
    int         results_seen  = 0;  // result transactions taken

    base64_stream_decoder_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (char_bus),
        .decoded (byte_bus)
    );

    always
    begin
        #(HalfPeriod) clk = 1'b1;
        #(HalfPeriod) clk = 1'b0;
    end

    // Hard stop: a correct run finishes long before this.
    initial
    begin
        #(LimitCycles * 2 * HalfPeriod);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Text builders
    // ------------------------------------------------------------------------
    function automatic logic is_space(input logic [7:0] c);
        return c == TabChar || c == LfChar || c == CrChar || c == SpaceChar;
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 3))
            0:       return TabChar;
            1:       return LfChar;
            2:       return CrChar;
            default: return SpaceChar;
        endcase
    endfunction

    // Pick a character for a 6-bit symbol; draw either alphabet for 62 and 63.
    function automatic logic [7:0] symbol_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'("A" + v);
        if (v < 6'd52)
            return 8'("a" + v - 8'd26);
        if (v < 6'd62)
            return 8'("0" + v - 8'd52);
        if (v == 6'd62)
            return ($urandom_range(0, 1) != 0) ? 8'("+") : 8'("-");
        return ($urandom_range(0, 1) != 0) ? 8'("/") : 8'("_");
    endfunction

    // Append a character, sometimes with whitespace ahead of it.
    function automatic void add_char(input logic [7:0] c);
        if ($urandom_range(0, 5) == 0)
            text_buf.push_back(space_char());
        text_buf.push_back(c);
    endfunction

    // Encode a random byte string as correctly padded base64.
    function automatic void make_text();
        logic [7:0]  data[$];
        logic [23:0] word;
        int          n;
        int          rem;
        text_buf.delete();
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6);
        repeat (n)
            data.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < n; i += 3)
        begin
            rem  = n - i;
            word = {data[i], ((rem > 1) ? data[i+1] : 8'h00),
                    ((rem > 2) ? data[i+2] : 8'h00)};
            add_char(symbol_char(word[23:18]));
            add_char(symbol_char(word[17:12]));
            add_char((rem > 1) ? symbol_char(word[11:6]) : PadChar);
            add_char((rem > 2) ? symbol_char(word[5:0]) : PadChar);
        end
        repeat ($urandom_range(0, 5))
            text_buf.push_back(space_char());
        if (text_buf.size() == 0)
            text_buf.push_back(SpaceChar);
    endfunction

    // Break a well-formed text in one of several ways.
    function automatic void spoil_text();
        int j;
        int k;
        case ($urandom_range(0, 5))
            0: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            1: text_buf.insert($urandom_range(0, text_buf.size()),
                               8'($urandom_range(128, 255)));
            2:
            begin
                // drop the last symbol: leaves an open group or a lone pad
                k = text_buf.size() - 1;
                while (k >= 0 && is_space(text_buf[k]))
                    k--;
                if (k >= 0)
                    text_buf.delete(k);
                if (text_buf.size() == 0)
                    text_buf.push_back(SpaceChar);
            end
            3: text_buf.push_back("Q");
            4: text_buf.insert($urandom_range(0, text_buf.size()), PadChar);
            default:
            begin
                // set discarded bits under the pad, or add a stray character
                j = 0;
                while (j < text_buf.size() && text_buf[j] != PadChar)
                    j++;
                if (j == text_buf.size())
                    text_buf.push_back("*");
                else
                begin
                    k = j - 1;
                    while (k >= 0 && is_space(text_buf[k]))
                        k--;
                    if (k >= 0)
                        text_buf[k] = "B";
                end
            end
        endcase
    endfunction

    function automatic void make_noise();
        text_buf.delete();
        repeat ($urandom_range(1, 6))
            text_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one character and hold it until the design takes it. Between
    // bursts, sometimes drop valid for a random gap.
    task automatic offer_char(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                char_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        end
        char_bus.valid      <= 1'b1;
        char_bus.text_char  <= c;
        char_bus.final_char <= last;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        tracker.accept_char(c, last);
        sent_chars++;
        burst_left--;
    endtask

    task automatic send_text(input string s, input logic ends);
        for (int i = 0; i < s.len(); i++)
            offer_char(8'(s[i]), ends && (i == s.len() - 1));
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_buf.size(); i++)
            offer_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Stop offering and wait until every owed result has been delivered.
    // Always wait on a clock edge before the first check so valid is never
    // dropped and raised in the same step.
    task automatic wait_for_results();
        char_bus.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: take results, check them, and stall on a pattern of its own.
    // Modes rotate between always ready, coin flip, a fixed period and mostly
    // stalled. Twice the receiver holds off for a long stretch so the result
    // queue fills and the design backs up into the text channel.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int   mode;
        int   mode_left;
        int   phase;
        int   hold_left;
        int   holds_done;
        logic take;
        byte_bus.ready = 1'b0;
        mode       = 0;
        mode_left  = 20;
        phase      = 0;
        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (byte_bus.valid && byte_bus.ready)
            begin
                tracker.take_result(byte_bus.out_byte, byte_bus.end_status,
                                    byte_bus.decode_error);
                results_seen++;
            end
            if (!rst_n)
                continue;

            // start a long hold once enough traffic has gone through
            if (hold_left == 0 && holds_done < 2 &&
                results_seen >= ((holds_done == 0) ? 25 : 130))
            begin
                hold_left = HoldCycles;
                holds_done++;
            end

            phase++;
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;

            if (hold_left != 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       take = 1'b1;
                    1:       take = ($urandom_range(0, 1) != 0);
                    2:       take = (phase % 3) != 0;
                    default: take = ($urandom_range(0, 7) == 0);
                endcase
            end
            byte_bus.ready <= take;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic paused;
        char_bus.valid      = 1'b0;
        char_bus.text_char  = 8'h00;
        char_bus.final_char = 1'b0;
        rst_n               = 1'b0;
        paused              = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Whitespace-only text: clean end status, no bytes.
        send_text(" ", 1'b1);
        // Both alphabets and the symbol extremes, a padded two-byte group,
        // then four trailing whitespace characters of every kind.
        send_text("z9+-/_A=", 1'b0);
        offer_char(TabChar, 1'b0);
        offer_char(CrChar, 1'b0);
        offer_char(LfChar, 1'b0);
        offer_char(SpaceChar, 1'b1);
        // Nonzero bits under a double pad.
        send_text("AB==", 1'b1);
        // Data symbol between the two pads.
        send_text("AA=A", 1'b1);
        // Pad after a single symbol.
        send_text("A=", 1'b1);
        // Characters at the top of the byte range.
        offer_char(CharHigh, 1'b1);
        offer_char(MaxChar, 1'b1);
        // Lone pad left open at the end of the text.
        send_text("AA=", 1'b1);

        wait_for_results();

        // Random texts: mostly well-formed, some spoiled, some noise. Midway,
        // pause the sender until the design has caught up completely.
        sent_chars = 0;
        while (sent_chars < RandomItems)
        begin
            if (!paused && sent_chars >= RandomItems / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                make_noise();
            else
            begin
                make_text();
                if ($urandom_range(0, 9) < 3)
                    spoil_text();
            end
            send_buffer();
        end

        // Drain, then wait out the settling period so any extra result would show.
        wait_for_results();
        repeat (SettleWait) @(posedge clk);

        $display("Decoded %0d texts (%0d rejected) into %0d data bytes and %0d results,",
                 tracker.texts, tracker.bad_texts, tracker.data_bytes, results_seen);
        $display("with bursty input, random output stalls and two long output holds.");
        if (tracker.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
